@@ rtl/fsle_pkg.sv @@
`default_nettype none

package fsle_pkg;

	// Instruction classes as they arrive in the low bits of the input tuser.
	typedef enum logic [2:0] {
		KIND_LABEL   = 3'd0,
		KIND_JUMP    = 3'd1,
		KIND_STORE   = 3'd2,
		KIND_LOAD    = 3'd3,
		KIND_BARRIER = 3'd4,
		KIND_OTHER   = 3'd5
	} kind_t;

	localparam int unsigned OFFSET_W = 32;
	localparam int unsigned REG_W    = 8;
	localparam int unsigned IN_DATA_W  = 48;
	localparam int unsigned IN_USER_W  = 4;
	localparam int unsigned OUT_DATA_W = 8;

	// One decoded instruction as it sits in the input register.
	typedef struct packed {
		kind_t               kind;
		logic [OFFSET_W-1:0] slot_offset;
		logic [REG_W-1:0]    reg_id;
		logic                refs_frame;
	} req_t;

endpackage

`default_nettype wire

@@ rtl/fsle_table.sv @@
`default_nettype none

module fsle_table #(
	parameter int unsigned DEPTH = 16
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              advance,
	input  fsle_pkg::req_t   req,
	output logic             load_redundant
);

	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [DEPTH-1:0]                 valid_q;
	logic [fsle_pkg::OFFSET_W-1:0]    offset_q [DEPTH];
	logic [fsle_pkg::REG_W-1:0]       register_q [DEPTH];
	logic                             after_jump_q;
	logic [IDX_W-1:0]                 replace_q;

	logic [DEPTH-1:0] hit;
	logic [DEPTH-1:0] hit_reg;
	logic [DEPTH-1:0] free_first;
	logic [DEPTH-1:0] victim;
	logic [DEPTH-1:0] write_sel;
	logic             any_hit;
	logic             any_free;
	logic             found;
	logic             do_store;
	logic             do_clear;

	// Offsets among valid entries are unique, so at most one entry hits.
	always_comb begin
		for (int k = 0; k < DEPTH; k++) begin
			hit[k]     = valid_q[k] && (offset_q[k] == req.slot_offset);
			hit_reg[k] = hit[k] && (register_q[k] == req.reg_id);
		end
	end

	always_comb begin
		found      = 1'b0;
		free_first = '0;
		for (int k = 0; k < DEPTH; k++) begin
			if (!valid_q[k] && !found) begin
				free_first[k] = 1'b1;
				found         = 1'b1;
			end
		end
	end

	always_comb begin
		victim = '0;
		victim[replace_q] = 1'b1;
	end

	assign any_hit  = |hit;
	assign any_free = |free_first;

	always_comb begin
		if (any_hit) begin
			write_sel = hit;
		end else if (any_free) begin
			write_sel = free_first;
		end else begin
			write_sel = victim;
		end
	end

	always_comb begin
		do_store = 1'b0;
		do_clear = 1'b0;
		case (req.kind)
			fsle_pkg::KIND_LABEL:   do_clear = after_jump_q;
			fsle_pkg::KIND_STORE:   do_store = 1'b1;
			fsle_pkg::KIND_BARRIER: do_clear = 1'b1;
			fsle_pkg::KIND_OTHER:   do_clear = req.refs_frame;
			default: begin
				do_store = 1'b0;
				do_clear = 1'b0;
			end
		endcase
	end

	assign load_redundant = (req.kind == fsle_pkg::KIND_LOAD) && (|hit_reg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			after_jump_q <= 1'b0;
			replace_q    <= '0;
		end else if (advance) begin
			if (do_clear) begin
				valid_q <= '0;
			end else if (do_store) begin
				valid_q <= valid_q | write_sel;
			end
			if (req.kind == fsle_pkg::KIND_JUMP) begin
				after_jump_q <= 1'b1;
			end else if (req.kind == fsle_pkg::KIND_LABEL) begin
				after_jump_q <= 1'b0;
			end
			if (do_store && !any_hit && !any_free) begin
				if (replace_q == IDX_W'(DEPTH - 1)) begin
					replace_q <= '0;
				end else begin
					replace_q <= replace_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && do_store) begin
			for (int k = 0; k < DEPTH; k++) begin
				if (write_sel[k]) begin
					offset_q[k]   <= req.slot_offset;
					register_q[k] <= req.reg_id;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/frame_slot_load_eliminator_top.sv @@
// Frame slot load eliminator: store-to-load forwarding over frame-pointer slots.
// Input stream (s_*): one classified instruction per item. s_tuser carries the
// instruction class and the frame-reference flag; s_tdata carries the slot
// offset and the register. Output stream (m_*): exactly one item per input
// item, in order, whose bit 0 says the load can be removed.
// Each item passes through an input register, a tag compare and table
// update, and an output register. m_tvalid rises once the item has moved
// from the input register into the output register, which waits while a
// held result is not taken. Throughput is one item per cycle while m_tready
// stays high, set by the compare and write of the associative table, which
// must see the update of the previous item.
// When the receiver holds m_tready low the result stays in the output
// register and one more item is still accepted into the input register; after
// that s_tready drops until the result is taken. The table only changes when
// an item moves from the input register to the output register.
// Asynchronous reset empties both registers, invalidates every table entry,
// clears the jump flag and the round-robin replacement pointer. There is no
// clearing pass; the block takes items as soon as reset is released.
`default_nettype none

module frame_slot_load_eliminator_top #(
	parameter int unsigned TABLE_DEPTH = 16
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	// [31:0] slot_offset (signed), [39:32] reg_id, [47:40] zero
	input  wire  [fsle_pkg::IN_DATA_W-1:0]     s_tdata,
	// [2:0] req_type, [3] refs_frame
	input  wire  [fsle_pkg::IN_USER_W-1:0]     s_tuser,
	output logic                               m_tvalid,
	input  wire                                m_tready,
	// [0] load_redundant, [7:1] zero
	output logic [fsle_pkg::OUT_DATA_W-1:0]    m_tdata
);

	logic           req_valid_s1;
	fsle_pkg::req_t req_s1;
	logic           out_valid_q;
	logic           redundant_q;
	logic           redundant;
	logic           advance;

	// The item in the input register is resolved when the output register
	// is empty or being drained in the same cycle.
	assign advance  = req_valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !req_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			req_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1.kind        <= fsle_pkg::kind_t'(s_tuser[2:0]);
			req_s1.refs_frame  <= s_tuser[3];
			req_s1.slot_offset <= s_tdata[31:0];
			req_s1.reg_id      <= s_tdata[39:32];
		end
	end

	fsle_table #(
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.req            (req_s1),
		.load_redundant (redundant)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			redundant_q <= redundant;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, redundant_q};

endmodule

`default_nettype wire

@@ rtl/fsle_checker.sv @@
`default_nettype none

module fsle_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [7:0]  m_tdata
);

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Input backpressure only comes from a stalled, full output register.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output stall");

	// With both stages full and stalled, the input side frees up exactly
	// when the output is taken.
	a_ready_follow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready && !s_tready |=> s_tready == m_tready)
		else $error("input ready does not follow output drain");

	// Padding bits of the result are zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:1] == 7'd0)
		else $error("nonzero padding in result");

endmodule

bind frame_slot_load_eliminator_top fsle_checker u_fsle_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
